FILE: sv/text_cursor_layout_core_defines.svh
// assertion macros shared by the text cursor layout rtl
`ifndef TEXT_CURSOR_LAYOUT_CORE_DEFINES_SVH
`define TEXT_CURSOR_LAYOUT_CORE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define TCL_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define TCL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/tcl_pkg.sv
// types and constants of the text cursor layout core
package tcl_pkg;

    localparam int unsigned IN_TDATA_W  = 64;
    localparam int unsigned OUT_TDATA_W = 80;

    localparam logic [7:0] LEAD_MIN_EXCL  = 8'h80;
    localparam logic [7:0] ASCII_SPACE    = 8'h20;
    localparam logic [7:0] ASCII_SPLIT    = 8'h5F;
    localparam logic [7:0] ASCII_DEL      = 8'h7F;
    localparam logic [7:0] ASCII_NEWLINE  = 8'h0A;
    localparam logic [7:0] FULL_WIDTH_ROW = 8'hA3;
    localparam logic [7:0] FULL_WIDTH_OFS = 8'h21;

    typedef enum logic {
        KIND_START = 1'b0,
        KIND_TEXT  = 1'b1
    } t_kind;

    typedef enum logic [1:0] {
        CFG_CHAR_WIDTH  = 2'd0,
        CFG_CHAR_HEIGHT = 2'd1,
        CFG_FONT_LOADED = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic        kind;
        logic [15:0] start_x;
        logic [15:0] start_y;
        logic        follow_x;
        logic        follow_y;
        logic [14:0] wrap_width;
        logic [7:0]  text_byte;
        logic        last_byte;
    } t_item;

    typedef struct packed {
        logic        lead_pending;
        logic [7:0]  lead_code;
        logic [15:0] line_origin_x;
        logic [15:0] pen_offset;
        logic [15:0] pen_y;
        logic [15:0] wrap_limit;
        logic        skip_newline;
        logic [15:0] last_cursor_x;
        logic [15:0] last_cursor_y;
    } t_state;

    typedef struct packed {
        logic              draw_glyph;
        logic signed [15:0] glyph_x;
        logic signed [15:0] glyph_y;
        logic [7:0]        code_first;
        logic [7:0]        code_next;
        logic signed [15:0] cursor_x;
        logic signed [15:0] cursor_y;
    } t_result;

    typedef struct packed {
        logic [7:0] char_width;
        logic [7:0] char_height;
        logic       font_loaded;
    } t_cfg;

endpackage

FILE: sv/tcl_step.sv
// per-byte layout step: next pen state and the result for one item
module tcl_step (
    input  tcl_pkg::t_state  i_state,
    input  tcl_pkg::t_item   i_item,
    input  tcl_pkg::t_cfg    i_cfg,
    output tcl_pkg::t_state  o_state,
    output tcl_pkg::t_result o_result
);
    import tcl_pkg::*;

    logic [7:0]  w_byte;
    logic        w_is_newline;
    logic        w_draw;
    logic [7:0]  w_c1;
    logic [7:0]  w_c2;
    logic [15:0] w_offset_a;
    logic [15:0] w_pen_y_a;
    logic [15:0] w_pen_y_b;
    logic        w_wrap;
    logic        w_check_wrap;
    logic [15:0] w_origin;
    logic [15:0] w_offset;
    logic [15:0] w_cursor_x;
    logic [8:0]  w_min_wrap;
    logic [15:0] w_gx;
    logic [15:0] w_gy;
    t_state      w_st;

    assign w_byte       = i_item.text_byte;
    assign w_is_newline = (w_byte == ASCII_NEWLINE);
    assign w_min_wrap   = {i_cfg.char_width, 1'b0};
    assign w_gx         = i_state.line_origin_x + i_state.pen_offset;
    assign w_gy         = i_state.pen_y;

    always_comb begin
        w_st         = i_state;
        w_draw       = 1'b0;
        w_c1         = '0;
        w_c2         = '0;
        w_offset_a   = i_state.pen_offset;
        w_pen_y_a    = i_state.pen_y;
        w_check_wrap = 1'b0;

        if (i_item.kind == KIND_START) begin
            w_st.line_origin_x = i_item.follow_x ? i_state.last_cursor_x : i_item.start_x;
            w_pen_y_a          = i_item.follow_y ? i_state.last_cursor_y : i_item.start_y;
            w_offset_a         = '0;
            w_st.wrap_limit    = ({1'b0, i_item.wrap_width} < {7'd0, w_min_wrap}) ?
                                 16'd0 : {1'b0, i_item.wrap_width};
            w_st.lead_pending  = 1'b0;
            w_st.lead_code     = '0;
            w_st.skip_newline  = 1'b0;
        end else if (i_state.lead_pending) begin
            // second byte of a pair is taken whatever it is
            w_draw            = 1'b1;
            w_c1              = i_state.lead_code;
            w_c2              = w_byte;
            w_st.lead_pending = 1'b0;
            w_offset_a        = i_state.pen_offset + {8'd0, i_cfg.char_width};
            w_check_wrap      = 1'b1;
        end else if (i_state.skip_newline && w_is_newline) begin
            // newline right after an automatic wrap is swallowed
            w_st.skip_newline = 1'b0;
        end else if ((w_byte > LEAD_MIN_EXCL) && !i_item.last_byte) begin
            w_st.skip_newline = 1'b0;
            w_st.lead_pending = 1'b1;
            w_st.lead_code    = w_byte;
        end else begin
            w_st.skip_newline = 1'b0;
            if ((w_byte > ASCII_SPACE) && (w_byte < ASCII_SPLIT)) begin
                w_draw = 1'b1;
                w_c1   = FULL_WIDTH_ROW;
                w_c2   = ASCII_SPACE + w_byte;
            end else if ((w_byte >= ASCII_SPLIT) && (w_byte < ASCII_DEL)) begin
                w_draw = 1'b1;
                w_c1   = FULL_WIDTH_ROW;
                w_c2   = FULL_WIDTH_OFS + w_byte;
            end
            if (w_is_newline) begin
                w_offset_a = '0;
                w_pen_y_a  = i_state.pen_y + {8'd0, i_cfg.char_height};
            end else begin
                w_offset_a = i_state.pen_offset + {9'd0, i_cfg.char_width[7:1]};
            end
            w_check_wrap = 1'b1;
        end

        w_wrap = w_check_wrap && (w_st.wrap_limit != 16'd0) && (w_offset_a > w_st.wrap_limit);
        if (w_wrap) begin
            w_st.skip_newline = !i_item.last_byte;
        end
    end

    assign w_offset   = w_wrap ? 16'd0 : w_offset_a;
    assign w_pen_y_b  = w_wrap ? (w_pen_y_a + {8'd0, i_cfg.char_height}) : w_pen_y_a;
    assign w_origin   = w_st.line_origin_x;
    assign w_cursor_x = w_origin + w_offset;

    always_comb begin
        o_state  = i_state;
        o_result = '0;
        if (!i_cfg.font_loaded) begin
            // item ignored, pen reported as it stands
            o_result.cursor_x = i_state.line_origin_x + i_state.pen_offset;
            o_result.cursor_y = i_state.pen_y;
        end else begin
            o_state               = w_st;
            o_state.pen_offset    = w_offset;
            o_state.pen_y         = w_pen_y_b;
            o_state.last_cursor_x = w_cursor_x;
            o_state.last_cursor_y = w_pen_y_b;
            o_result.draw_glyph   = w_draw;
            o_result.glyph_x      = w_draw ? w_gx : 16'd0;
            o_result.glyph_y      = w_draw ? w_gy : 16'd0;
            o_result.code_first   = w_c1;
            o_result.code_next    = w_c2;
            o_result.cursor_x     = w_cursor_x;
            o_result.cursor_y     = w_pen_y_b;
        end
    end

endmodule

FILE: sv/text_cursor_layout_core.sv
// each result is registered, in the result register or, under output stall, in the skid entry
// throughput: one byte per cycle while input ready is high; the pen state is updated in the same cycle
// a two-entry output stage (result register plus skid) keeps input flowing
// under output stall; input ready drops only while the skid entry is full
// reset (synchronous, active low) clears the pen state and restores config defaults
`include "text_cursor_layout_core_defines.svh"

module text_cursor_layout_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // config write channel
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [1:0]                       i_cfg_index,
    input  logic [7:0]                       i_cfg_data,
    // text stream in
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // start_x[15:0], start_y[31:16], follow_x[32], follow_y[33],
    // wrap_width[48:34], text_byte[56:49], zero fill [63:57]
    input  logic [tcl_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // kind[0]
    input  logic [0:0]                       s_axis_tuser,
    input  logic                             s_axis_tlast,
    // glyph stream out
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // glyph_x[15:0], glyph_y[31:16], code_first[39:32], code_next[47:40],
    // cursor_x[63:48], cursor_y[79:64]
    output logic [tcl_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    // draw_glyph[0]
    output logic [0:0]                       m_axis_tuser
);
    import tcl_pkg::*;

    t_cfg    r_cfg;
    t_state  r_state;
    t_state  n_state;
    t_item   w_item;
    t_result w_result;
    t_result r_out;
    t_result r_skid;
    logic    r_out_valid;
    logic    r_skid_valid;
    logic    w_in_acc;
    logic    w_out_acc;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.char_width  <= 8'd16;
            r_cfg.char_height <= 8'd16;
            r_cfg.font_loaded <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_CHAR_WIDTH:  r_cfg.char_width  <= i_cfg_data;
                CFG_CHAR_HEIGHT: r_cfg.char_height <= i_cfg_data;
                CFG_FONT_LOADED: r_cfg.font_loaded <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign w_item.kind       = s_axis_tuser[0];
    assign w_item.start_x    = s_axis_tdata[15:0];
    assign w_item.start_y    = s_axis_tdata[31:16];
    assign w_item.follow_x   = s_axis_tdata[32];
    assign w_item.follow_y   = s_axis_tdata[33];
    assign w_item.wrap_width = s_axis_tdata[48:34];
    assign w_item.text_byte  = s_axis_tdata[56:49];
    assign w_item.last_byte  = s_axis_tlast;

    tcl_step u_step (
        .i_state  (r_state),
        .i_item   (w_item),
        .i_cfg    (r_cfg),
        .o_state  (n_state),
        .o_result (w_result)
    );

    assign s_axis_tready = !r_skid_valid;
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_out_acc     = r_out_valid && m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (w_in_acc) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || w_out_acc) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= w_in_acc;
            end
        end else if (w_in_acc) begin
            r_skid_valid <= 1'b1;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (!r_out_valid || w_out_acc) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (w_in_acc) begin
                r_out <= w_result;
            end
        end else if (w_in_acc) begin
            r_skid <= w_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.draw_glyph;
    assign m_axis_tdata  = {r_out.cursor_y, r_out.cursor_x, r_out.code_next,
                            r_out.code_first, r_out.glyph_y, r_out.glyph_x};

    `TCL_ASSERT_NOW(a_skid_behind_out, i_clk, i_rst_n, r_skid_valid, r_out_valid,
        "skid entry held without a result in front")
    `TCL_ASSERT_NEXT(a_stall_fills_skid, i_clk, i_rst_n,
        w_in_acc && r_out_valid && !m_axis_tready, r_skid_valid,
        "transfer under output stall did not land in skid")
    `TCL_ASSERT_NEXT(a_idle_font_holds, i_clk, i_rst_n,
        w_in_acc && !r_cfg.font_loaded, $stable(r_state),
        "pen state moved while font not loaded")
    `TCL_ASSERT_NEXT(a_pair_completes, i_clk, i_rst_n,
        w_in_acc && r_cfg.font_loaded && (w_item.kind == KIND_TEXT) && r_state.lead_pending,
        !r_state.lead_pending, "lead byte still pending after its pair")
    `TCL_ASSERT_NEXT(a_start_clears, i_clk, i_rst_n,
        w_in_acc && r_cfg.font_loaded && (w_item.kind == KIND_START),
        !r_state.lead_pending && !r_state.skip_newline,
        "start transfer left pending flags set")

endmodule
